[rtl/lfu_page_replacement_macros.svh]
// ---------------------------------------------------------------------------
// LFU page replacement assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef LFU_PAGE_REPLACEMENT_MACROS_SVH
`define LFU_PAGE_REPLACEMENT_MACROS_SVH

// A condition that must hold at every clock edge.
`define LFU_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// A condition that must hold in the cycle after the antecedent.
`define LFU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/lfu_pkg.sv]
// ---------------------------------------------------------------------------
// LFU page replacement package
// Payload types, frame entry and cell control types, and fixed constants.
// ---------------------------------------------------------------------------
package lfu_pkg;

  localparam int PAGE_W  = 7;
  localparam int FREQ_W  = 16;
  localparam int FAULT_W = 32;
  localparam int CFG_W   = 4;
  // Frame indexes and counts, wide enough for the largest frame row.
  localparam int IDX_W   = 6;
  localparam int PAGE_SPAN = 1 << PAGE_W;

  localparam logic [CFG_W-1:0]   CFG_RESET = 4'd3;
  localparam logic [FREQ_W-1:0]  FREQ_MAX  = '1;
  localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic              last_reference;
  } in_t;

  typedef struct packed {
    logic               hit;
    logic               evicted_valid;
    logic [PAGE_W-1:0]  evicted_page;
    logic [FAULT_W-1:0] fault_total;
    logic               sequence_done;
  } out_t;

  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic [FREQ_W-1:0] freq;
  } entry_t;

  typedef struct packed {
    logic             upd;
    logic [IDX_W-1:0] pos;
    logic [IDX_W-1:0] rem_len;
    entry_t           ins;
  } cell_ctrl_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

endpackage

[rtl/lfu_ram.sv]
// ---------------------------------------------------------------------------
// LFU generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module lfu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/lfu_cell.sv]
// ---------------------------------------------------------------------------
// LFU frame cell
// Holds one frame of the ordered list and takes part in remove and insert.
// ---------------------------------------------------------------------------
module lfu_cell
  import lfu_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  entry_t     prev_rem,
  input  logic       prev_le,
  input  entry_t     nxt,
  output entry_t     own,
  output entry_t     rem,
  output logic       le
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  // After removal each cell at or above the removed place takes its right neighbour.
  assign rem = (MY_IDX < ctrl.pos) ? own : nxt;
  assign le  = (MY_IDX < ctrl.rem_len) && (rem.freq <= ctrl.ins.freq);

  always_ff @(posedge clk) begin
    if (ctrl.upd) begin
      if (le) begin
        own <= rem;
      end else if (MY_IDX == '0 || prev_le) begin
        own <= ctrl.ins;
      end else begin
        own <= prev_rem;
      end
    end
  end

endmodule

[rtl/lfu_page_replacement.sv]
// A result is registered into out_item when the update state fires after the
// transfer; it waits while the receiver stalls. A new reference is taken only
// in idle, where the RAM read is registered; the cells then shift and insert.
// Reset (rst, synchronous) empties the frames, zeroes the fault count, marks every
// stored frequency as zero and sets the frame count register to three; the end
// of a sequence does the same but keeps the frame count register.
// ---------------------------------------------------------------------------
// LFU page replacement
// Least frequently used frame list with oldest-first tie-break and fault count.
// ---------------------------------------------------------------------------
module lfu_page_replacement
  import lfu_pkg::*;
#(
  parameter int MAX_FRAMES = 8,
  parameter int PAGE_RANGE = 128
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_t              in_item,
  output logic             out_valid,
  input  logic             out_stall,
  output out_t             out_item,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data
);

  `include "lfu_page_replacement_macros.svh"

  localparam int AW = $clog2(PAGE_RANGE);

  function automatic logic [PAGE_SPAN*AW-1:0] mod_table();
    logic [PAGE_SPAN*AW-1:0] t;
    int r;
    t = '0;
    r = 0;
    for (int v = 0; v < PAGE_SPAN; v++) begin
      t[v*AW +: AW] = AW'(r);
      r = (r == PAGE_RANGE - 1) ? 0 : r + 1;
    end
    return t;
  endfunction

  localparam logic [PAGE_SPAN*AW-1:0] MOD_TAB = mod_table();

  state_t             state, state_next;
  logic [CFG_W-1:0]   frames_in_use;
  logic [PAGE_W-1:0]  page_r;
  logic               last_r;
  logic [IDX_W-1:0]   filled;
  logic [FAULT_W-1:0] faults;
  logic [PAGE_RANGE-1:0] fvalid;

  logic               in_acc, exec_fire;
  logic [PAGE_W-1:0]  in_red;
  logic [AW-1:0]      ram_raddr, ram_waddr;
  logic               ram_we;
  logic [FREQ_W-1:0]  ram_rdata, ram_wdata;

  entry_t             own_q [MAX_FRAMES];
  entry_t             rem_w [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] le_w;
  logic [MAX_FRAMES-1:0] match_vec;
  cell_ctrl_t         ctrl;

  logic [IDX_W-1:0]   fiu_ext, cap, pos_hit, rem_len;
  logic               hit, full, evict;
  logic [FREQ_W-1:0]  hit_freq, base_freq, new_freq;
  logic [FAULT_W-1:0] faults_next;
  logic [IDX_W-1:0]   filled_next;

  // Page number folded into the page range.
  assign in_red = PAGE_W'(MOD_TAB[in_item.page*AW +: AW]);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_acc) state_next = ST_EXEC;
      ST_EXEC: if (exec_fire) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    exec_fire = 1'b0;
    unique case (state)
      ST_IDLE: in_stall = 1'b0;
      ST_EXEC: exec_fire = !out_valid || !out_stall;
      default: in_stall = 1'b1;
    endcase
  end

  assign in_acc    = in_valid && !in_stall;
  assign ram_raddr = (state == ST_IDLE) ? AW'(in_red) : AW'(page_r);

  lfu_ram #(
    .WIDTH(FREQ_W),
    .DEPTH(PAGE_RANGE)
  ) u_freq_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    hit_freq = '0;
    pos_hit  = '0;
    for (int i = 0; i < MAX_FRAMES; i++) begin
      match_vec[i] = (own_q[i].page == page_r) && (IDX_W'(i) < filled);
      if (match_vec[i]) begin
        hit_freq = hit_freq | own_q[i].freq;
        pos_hit  = pos_hit | IDX_W'(i);
      end
    end
  end

  always_comb begin
    fiu_ext = IDX_W'(frames_in_use);
    if (fiu_ext == '0) begin
      cap = IDX_W'(1);
    end else if (fiu_ext > IDX_W'(MAX_FRAMES)) begin
      cap = IDX_W'(MAX_FRAMES);
    end else begin
      cap = fiu_ext;
    end
    hit   = |match_vec;
    full  = filled >= cap;
    evict = !hit && full;

    base_freq = hit ? hit_freq : (fvalid[AW'(page_r)] ? ram_rdata : '0);
    new_freq  = (base_freq == FREQ_MAX) ? base_freq : base_freq + 1'b1;

    rem_len     = (hit || full) ? filled - 1'b1 : filled;
    filled_next = rem_len + 1'b1;
    faults_next = (hit || faults == FAULT_MAX) ? faults : faults + 1'b1;

    ctrl.upd      = exec_fire;
    ctrl.pos      = hit ? pos_hit : (full ? '0 : '1);
    ctrl.rem_len  = rem_len;
    ctrl.ins.page = page_r;
    ctrl.ins.freq = new_freq;

    // The evicted page leaves the row with its count lowered by one.
    ram_we    = exec_fire && evict;
    ram_waddr = AW'(own_q[0].page);
    ram_wdata = (own_q[0].freq == '0) ? '0 : own_q[0].freq - 1'b1;
  end

  for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_cell
    entry_t nb_next;
    entry_t nb_prev;
    logic   nb_le;
    if (g == MAX_FRAMES - 1) begin : g_tail
      assign nb_next = own_q[g];
    end else begin : g_body
      assign nb_next = own_q[g+1];
    end
    if (g == 0) begin : g_head
      assign nb_prev = '0;
      assign nb_le   = 1'b0;
    end else begin : g_link
      assign nb_prev = rem_w[g-1];
      assign nb_le   = le_w[g-1];
    end
    lfu_cell #(
      .IDX(g)
    ) u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .prev_rem(nb_prev),
      .prev_le (nb_le),
      .nxt     (nb_next),
      .own     (own_q[g]),
      .rem     (rem_w[g]),
      .le      (le_w[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      frames_in_use <= CFG_RESET;
      filled        <= '0;
      faults        <= '0;
      fvalid        <= '0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        frames_in_use <= cfg_data;
      end
      if (exec_fire) begin
        out_valid <= 1'b1;
        if (last_r) begin
          filled <= '0;
          faults <= '0;
          fvalid <= '0;
        end else begin
          filled <= filled_next;
          faults <= faults_next;
          if (ram_we) begin
            fvalid[ram_waddr] <= 1'b1;
          end
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      page_r <= in_red;
      last_r <= in_item.last_reference;
    end
    if (exec_fire) begin
      out_item.hit           <= hit;
      out_item.evicted_valid <= evict;
      out_item.evicted_page  <= evict ? own_q[0].page : '0;
      out_item.fault_total   <= faults_next;
      out_item.sequence_done <= last_r;
    end
  end

  `LFU_ASSERT_ALWAYS(a_match_onehot, $onehot0(match_vec), "resident page matches two frames")
  `LFU_ASSERT_ALWAYS(a_filled_range, filled <= IDX_W'(MAX_FRAMES), "frame count overflow")
  `LFU_ASSERT_NEXT(a_accept_exec, in_acc, state == ST_EXEC, "transfer did not start update")
  `LFU_ASSERT_NEXT(a_fire_result, exec_fire, out_valid, "update produced no result")

endmodule

[dv/tb.sv]
// ---------------------------------------------------------------------------
// LFU page replacement testbench
// Drives page references through the valid/stall channel, predicts each result
// with an independent frame-list model and compares every field in order.
// ---------------------------------------------------------------------------
module tb
  import lfu_pkg::*;
;

  localparam int NFRAMES = 8;
  localparam int NPAGES = 128;
  localparam int LIMIT_CYCLES = 400000;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  in_t in_item;
  logic out_valid;
  logic out_stall;
  out_t out_item;
  logic cfg_we;
  logic [CFG_W-1:0] cfg_data;

  // Predictor state.
  logic [PAGE_W-1:0] lst_page[NFRAMES];
  int unsigned lst_len;
  logic [FREQ_W-1:0] use_count[NPAGES];
  logic [FAULT_W-1:0] fault_count;
  logic [CFG_W-1:0] frame_cfg;

  out_t expected_results[$];
  int errors;
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_off;
  longint unsigned cycle_count;

  lfu_page_replacement u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic clear_lfu();
    for (int i = 0; i < NFRAMES; i++) lst_page[i] = '0;
    for (int i = 0; i < NPAGES; i++) use_count[i] = '0;
    lst_len = 0;
    fault_count = '0;
  endtask

  function automatic void drop_at(int unsigned pos);
    for (int unsigned i = pos; i + 1 < lst_len; i++) lst_page[i] = lst_page[i + 1];
    lst_len--;
  endfunction

  task automatic predict_reference(in_t item);
    out_t res;
    int unsigned cap;
    int unsigned pos;
    int unsigned k;
    logic [PAGE_W-1:0] pg;
    logic [PAGE_W-1:0] tmp;
    bit found;
    pg = item.page;
    cap = frame_cfg;
    if (cap == 0) cap = 1;
    if (cap > NFRAMES) cap = NFRAMES;
    found = 0;
    pos = 0;
    res = '0;
    for (int unsigned i = 0; i < lst_len; i++) begin
      if (!found && lst_page[i] == pg) begin
        found = 1;
        pos = i;
      end
    end
    if (found) begin
      if (use_count[pg] != FREQ_MAX) use_count[pg]++;
      drop_at(pos);
    end else begin
      if (lst_len >= cap) begin
        res.evicted_valid = 1'b1;
        res.evicted_page = lst_page[0];
        if (use_count[lst_page[0]] != 0) use_count[lst_page[0]]--;
        drop_at(0);
      end
      if (use_count[pg] != FREQ_MAX) use_count[pg]++;
      if (fault_count != FAULT_MAX) fault_count++;
    end
    lst_page[lst_len] = pg;
    lst_len++;
    k = lst_len - 1;
    while (k > 0 && use_count[lst_page[k - 1]] > use_count[lst_page[k]]) begin
      tmp = lst_page[k - 1];
      lst_page[k - 1] = lst_page[k];
      lst_page[k] = tmp;
      k--;
    end
    res.hit = found;
    res.fault_total = fault_count;
    res.sequence_done = item.last_reference;
    expected_results.push_back(res);
    if (item.last_reference) clear_lfu();
  endtask

  // Sends one reference and records its expected result on transfer.
  // Valid is only dropped when the sender idles or the stream is drained.
  task automatic send_reference(logic [PAGE_W-1:0] pg, logic last_ref);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= '{page: pg, last_reference: last_ref};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_reference('{page: pg, last_reference: last_ref});
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_frames(logic [CFG_W-1:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    frame_cfg = value;
  endtask

  // Result checker.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_item);
        errors++;
      end else begin
        out_t e;
        e = expected_results.pop_front();
        if (e.hit !== out_item.hit)
          $display("%0t: hit exp %0d got %0d", $time, e.hit, out_item.hit);
        if (e.evicted_valid !== out_item.evicted_valid)
          $display("%0t: evicted_valid exp %0d got %0d", $time, e.evicted_valid,
                   out_item.evicted_valid);
        if (e.evicted_page !== out_item.evicted_page)
          $display("%0t: evicted_page exp %0d got %0d", $time, e.evicted_page,
                   out_item.evicted_page);
        if (e.fault_total !== out_item.fault_total)
          $display("%0t: fault_total exp %0d got %0d", $time, e.fault_total,
                   out_item.fault_total);
        if (e.sequence_done !== out_item.sequence_done)
          $display("%0t: sequence_done exp %0d got %0d", $time, e.sequence_done,
                   out_item.sequence_done);
        if (e !== out_item) errors++;
      end
    end
  end

  // Receiver stall generator, with an optional long hold-off.
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic test_directed();
    // Extremes of page, hits, evictions, ties and the end of a sequence.
    send_reference(7'd0, 1'b0);
    send_reference(7'd127, 1'b0);
    send_reference(7'd0, 1'b0);
    send_reference(7'd85, 1'b0);
    send_reference(7'd42, 1'b0);
    send_reference(7'd127, 1'b0);
    send_reference(7'd85, 1'b0);
    send_reference(7'd1, 1'b0);
    send_reference(7'd0, 1'b1);
    send_reference(7'd0, 1'b1);
    send_reference(7'd127, 1'b0);
    send_reference(7'd127, 1'b0);
    send_reference(7'd126, 1'b1);
  endtask

  task automatic test_frame_counts();
    logic [CFG_W-1:0] values[6];
    values = '{4'd0, 4'd1, 4'd8, 4'd15, 4'd5, 4'd2};
    foreach (values[v]) begin
      write_frames(values[v]);
      for (int i = 0; i < 12; i++) send_reference(PAGE_W'($urandom_range(5)), i == 11);
    end
    // Lower the frame count mid-sequence.
    write_frames(4'd8);
    for (int i = 0; i < 10; i++) send_reference(PAGE_W'(i), 1'b0);
    write_frames(4'd2);
    for (int i = 0; i < 8; i++) send_reference(PAGE_W'($urandom_range(12)), i == 7);
  endtask

  task automatic run_random(int n);
    int unsigned span;
    for (int i = 0; i < n; i++) begin
      span = ($urandom_range(9) == 0) ? 127 : 3 + $urandom_range(12);
      send_reference(PAGE_W'($urandom_range(span)), $urandom_range(39) == 0);
    end
  endtask

  task automatic test_random();
    int idle[4] = '{0, 70, 0, 38};
    int stall[4] = '{0, 0, 70, 38};
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle[ph];
      recv_stall_pct = stall[ph];
      write_frames(4'($urandom_range(15)));
      run_random(300);
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (60) @(posedge clk);
        hold_off = 1'b0;
      end
      run_random(40);
    join
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    errors = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off = 1'b0;
    cycle_count = 0;
    frame_cfg = CFG_RESET;
    clear_lfu();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_frame_counts();
    test_random();
    test_backpressure();
    write_frames(4'd8);
    run_random(200);
    drain();
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule

[filelist.f]
+incdir+rtl
rtl/lfu_pkg.sv
rtl/lfu_ram.sv
rtl/lfu_cell.sv
rtl/lfu_page_replacement.sv
dv/tb.sv
